// ===== sv/sfr_pkg.sv =====
package sfr_pkg;

  localparam logic [7:0] HDR_FIRST    = 8'h68;
  localparam logic [7:0] HDR_SECOND   = 8'h96;
  localparam logic [7:0] TYPE_REQUEST = 8'h05;
  localparam logic [7:0] TYPE_STATUS  = 8'h07;
  localparam int unsigned TYPE_ACK_BIT = 7;

  // Total frame lengths in bytes, header included.
  localparam int unsigned LONG_LEN = 7;
  localparam int unsigned ACK_LEN  = 6;

  // Positions of the payload bytes within a frame.
  localparam int unsigned POS_TYPE  = 2;
  localparam int unsigned POS_DATA0 = 4;
  localparam int unsigned POS_DATA1 = 5;

  localparam logic [7:0] TIMEOUT_RESET = 8'd55;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } command_e;

  typedef enum logic [2:0] {
    OUT_REQ_OK  = 3'd0,
    OUT_STAT_OK = 3'd1,
    OUT_ACK_OK  = 3'd2,
    OUT_CKS_BAD = 3'd3,
    OUT_FRAMING = 3'd4,
    OUT_TIMEOUT = 3'd5
  } outcome_e;

  typedef enum logic [1:0] {
    REQ_NONE    = 2'd0,
    REQ_DATA    = 2'd1,
    REQ_TIME    = 2'd2,
    REQ_MACHINE = 2'd3
  } request_e;

  typedef struct packed {
    outcome_e   outcome;
    logic [7:0] frame_type;
    request_e   request_code;
    logic [7:0] disk_state;
    logic [7:0] link_state;
  } result_t;

  // Handshake between the frame decoder and the result queue.
  typedef struct packed {
    logic    push;
    result_t data;
  } res_push_t;

endpackage

// ===== sv/sfr_if.sv =====
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;

  modport source (output valid, output command, output rx_byte, input ready);
  modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

interface sfr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] outcome;
  logic [7:0] frame_type;
  logic [1:0] request_code;
  logic [7:0] disk_state;
  logic [7:0] link_state;

  modport source (output valid, output outcome, output frame_type, output request_code,
                  output disk_state, output link_state, input ready);
  modport sink   (input valid, input outcome, input frame_type, input request_code,
                  input disk_state, input link_state, output ready);
endinterface

// ===== sv/sfr_core.sv =====
module sfr_core #(
  parameter int unsigned MAX_FRAME_BYTES = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                command_i,
  input  logic [7:0]          rx_byte_i,
  input  logic [7:0]          timeout_i,
  input  logic                room_i,
  output sfr_pkg::res_push_t  push_o
);

  localparam int unsigned IDX_W = $clog2(MAX_FRAME_BYTES);
  localparam logic [IDX_W-1:0] IDX_ONE   = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_TYPE  = IDX_W'(sfr_pkg::POS_TYPE);
  localparam logic [IDX_W-1:0] IDX_DATA0 = IDX_W'(sfr_pkg::POS_DATA0);
  localparam logic [IDX_W-1:0] IDX_DATA1 = IDX_W'(sfr_pkg::POS_DATA1);
  localparam logic [IDX_W-1:0] IDX_LONG  = IDX_W'(sfr_pkg::LONG_LEN - 1);
  localparam logic [IDX_W-1:0] IDX_ACK   = IDX_W'(sfr_pkg::ACK_LEN - 1);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(MAX_FRAME_BYTES - 1);

  // Input register.
  logic       in_valid_q, in_valid_d;
  logic       cmd_q;
  logic [7:0] byte_q;
  logic       accept, fire;

  // Frame state.
  logic             in_frame_q, in_frame_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [7:0]       idle_q, idle_d;
  logic [7:0]       type_q, type_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       data0_q, data0_d;
  logic [7:0]       data1_q, data1_d;
  logic [7:0]       disk_q, disk_d;
  logic [7:0]       link_q, link_d;

  logic       emit;
  logic [7:0] idle_inc;
  logic [7:0] cur_type;
  logic       is_long, is_ack;
  sfr_pkg::outcome_e outcome;
  sfr_pkg::request_e req_code;
  logic [7:0]        res_type;

  assign in_ready_o = !in_valid_q || room_i;
  assign accept     = in_valid_i && in_ready_o;
  assign fire       = in_valid_q && room_i;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  assign idle_inc = (idle_q == 8'hFF) ? idle_q : idle_q + 8'd1;
  assign cur_type = (idx_q == IDX_TYPE) ? byte_q : type_q;
  assign is_long  = (cur_type == sfr_pkg::TYPE_REQUEST) || (cur_type == sfr_pkg::TYPE_STATUS);
  assign is_ack   = cur_type[sfr_pkg::TYPE_ACK_BIT];

  always_comb begin
    in_frame_d = in_frame_q;
    idx_d      = idx_q;
    idle_d     = idle_q;
    type_d     = type_q;
    sum_d      = sum_q;
    data0_d    = data0_q;
    data1_d    = data1_q;
    disk_d     = disk_q;
    link_d     = link_q;
    emit       = 1'b0;
    outcome    = sfr_pkg::OUT_FRAMING;
    req_code   = sfr_pkg::REQ_NONE;
    res_type   = 8'h00;

    if (fire) begin
      if (cmd_q == sfr_pkg::CMD_TICK) begin
        if (in_frame_q) begin
          idle_d = idle_inc;
          if (idle_inc >= timeout_i) begin
            emit     = 1'b1;
            outcome  = sfr_pkg::OUT_TIMEOUT;
            res_type = (idx_q > IDX_TYPE) ? type_q : 8'h00;
          end
        end
      end else begin
        idle_d = 8'h00;
        if (!in_frame_q) begin
          if (byte_q == sfr_pkg::HDR_FIRST) begin
            in_frame_d = 1'b1;
            idx_d      = IDX_ONE;
            sum_d      = 8'h00;
          end
        end else if (idx_q == IDX_ONE) begin
          if (byte_q != sfr_pkg::HDR_SECOND) begin
            emit = 1'b1;
          end else begin
            idx_d = idx_q + IDX_ONE;
          end
        end else begin
          res_type = cur_type;
          if (is_long && idx_q >= IDX_LONG) begin
            emit = 1'b1;
            if (sum_q != byte_q) begin
              outcome = sfr_pkg::OUT_CKS_BAD;
            end else if (cur_type == sfr_pkg::TYPE_REQUEST) begin
              outcome  = sfr_pkg::OUT_REQ_OK;
              req_code = (data0_q[7:2] == 6'd0) ? sfr_pkg::request_e'(data0_q[1:0])
                                                : sfr_pkg::REQ_NONE;
            end else begin
              outcome = sfr_pkg::OUT_STAT_OK;
              disk_d  = data0_q;
              link_d  = data1_q;
            end
          end else if (is_ack && idx_q >= IDX_ACK) begin
            emit    = 1'b1;
            outcome = (sum_q != byte_q) ? sfr_pkg::OUT_CKS_BAD : sfr_pkg::OUT_ACK_OK;
          end else if (idx_q >= IDX_LAST) begin
            emit = 1'b1;
          end else begin
            idx_d  = idx_q + IDX_ONE;
            type_d = cur_type;
            sum_d  = sum_q + byte_q;
            if (idx_q == IDX_DATA0) begin
              data0_d = byte_q;
            end
            if (idx_q == IDX_DATA1) begin
              data1_d = byte_q;
            end
          end
        end
      end
      if (emit) begin
        in_frame_d = 1'b0;
        idx_d      = '0;
        idle_d     = 8'h00;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      in_frame_q <= 1'b0;
      idx_q      <= '0;
      idle_q     <= 8'h00;
      disk_q     <= 8'h00;
      link_q     <= 8'h00;
    end else begin
      in_valid_q <= in_valid_d;
      in_frame_q <= in_frame_d;
      idx_q      <= idx_d;
      idle_q     <= idle_d;
      disk_q     <= disk_d;
      link_q     <= link_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= command_i;
      byte_q <= rx_byte_i;
    end
    type_q  <= type_d;
    sum_q   <= sum_d;
    data0_q <= data0_d;
    data1_q <= data1_d;
  end

  assign push_o.push              = emit;
  assign push_o.data.outcome      = outcome;
  assign push_o.data.frame_type   = res_type;
  assign push_o.data.request_code = req_code;
  assign push_o.data.disk_state   = disk_d;
  assign push_o.data.link_state   = link_d;

endmodule

// ===== sv/sfr_res_queue.sv =====
module sfr_res_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sfr_pkg::res_push_t push_i,
  output logic               room_o,
  output logic               valid_o,
  input  logic               ready_i,
  output sfr_pkg::result_t   data_o
);

  // Two-entry queue: one result may wait while the next one is produced.
  sfr_pkg::result_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign room_o  = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i.push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i.push && pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i.push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      mem_q[wr_ptr_q] <= push_i.data;
    end
  end

endmodule

// ===== sv/serial_frame_receiver_unit.sv =====
// Serial frame receiver. Each input beat carries either one received serial
// byte or one millisecond tick; the block hunts for the header 0x68, checks the
// second byte 0x96, and assembles request, status and acknowledgement frames,
// producing at most one result beat when a frame ends (good frame, bad
// checksum, framing error or idle timeout). An input beat is taken in every
// cycle as long as the two-entry result queue has a free slot, so a result can
// wait on the output while the next beats are accepted. A beat is decoded
// while it sits in the input register and the queue has a free slot, and its
// result is written into the queue at the edge that ends its decode; the queue
// count is registered, so the result appears on the output after that edge.
// The rate is one beat per cycle while the queue has room; the decode step
// keeps a running checksum instead of summing the stored bytes. The idle
// timeout register may only be written while no beat is in flight.

module serial_frame_receiver_unit #(
  parameter int unsigned MAX_FRAME_BYTES = 7
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  sfr_in_if.sink      rx_i,
  sfr_out_if.source   res_o
);

  logic [7:0] timeout_q;

  // The timeout register is the only configuration state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= sfr_pkg::TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  sfr_pkg::res_push_t push;
  sfr_pkg::result_t   head;
  logic               room;

  // Frame decoder: input register, then the frame step.
  sfr_core #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(rx_i.valid),
    .in_ready_o(rx_i.ready),
    .command_i (rx_i.command),
    .rx_byte_i (rx_i.rx_byte),
    .timeout_i (timeout_q),
    .room_i    (room),
    .push_o    (push)
  );

  // Result queue: decouples the decoder from stalls on the output side.
  sfr_res_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .valid_o(res_o.valid),
    .ready_i(res_o.ready),
    .data_o (head)
  );

  assign res_o.outcome      = head.outcome;
  assign res_o.frame_type   = head.frame_type;
  assign res_o.request_code = head.request_code;
  assign res_o.disk_state   = head.disk_state;
  assign res_o.link_state   = head.link_state;

endmodule
